// ===== rtl/core/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character lookup of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_INVALID_CHAR = 3'd1,
    ERR_BAD_PAD      = 3'd2,
    ERR_LENGTH       = 3'd3,
    ERR_AFTER_PAD    = 3'd4
  } b64d_err_t;

  // One decoded group, or one error report, as handed from front to back.
  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  byte_count;
    b64d_err_t   err;
    logic        eot;
  } b64d_rec_t;

  typedef struct packed {
    logic ok;
    logic [5:0] value;
  } b64d_sextet_t;

  function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
    b64d_sextet_t s;
    logic [7:0] t;
    s = '0;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      s = '{ok: 1'b1, value: t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'd71;
      s = '{ok: 1'b1, value: t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'd4;
      s = '{ok: 1'b1, value: t[5:0]};
    end else if (c == 8'h2B) begin
      s = '{ok: 1'b1, value: 6'd62};
    end else if (c == 8'h2F) begin
      s = '{ok: 1'b1, value: 6'd63};
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the group state and queues one record for every
// completed group or detected error.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       char_code,
  input  logic             end_of_text,
  output logic             push,
  output b64d_pkg::b64d_rec_t push_rec
);
  import b64d_pkg::*;

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] store_r, store_nxt;
  logic        pad3_r, pad3_nxt;
  logic        padded_r, padded_nxt;
  logic        drop_r, drop_nxt;

  b64d_sextet_t sx;
  logic         is_pad;
  logic [5:0]   val;
  b64d_err_t    err;

  always_comb begin
    sx     = sextet_of(char_code);
    is_pad = (char_code == CHAR_PAD);
    val    = is_pad ? 6'd0 : sx.value;

    if (padded_r) begin
      err = ERR_AFTER_PAD;
    end else if (!sx.ok && !is_pad) begin
      err = ERR_INVALID_CHAR;
    end else if (is_pad && pos_r < 2'd2) begin
      err = ERR_BAD_PAD;
    end else if (pos_r == 2'd3 && pad3_r && !is_pad) begin
      err = ERR_BAD_PAD;
    end else if (end_of_text && pos_r != 2'd3) begin
      err = ERR_LENGTH;
    end else begin
      err = ERR_NONE;
    end

    pos_nxt    = pos_r;
    store_nxt  = store_r;
    pad3_nxt   = pad3_r;
    padded_nxt = padded_r;
    drop_nxt   = drop_r;
    push       = 1'b0;
    push_rec   = '{group_bits: {store_r, val}, byte_count: 2'd3, err: ERR_NONE,
                   eot: end_of_text};

    if (accept) begin
      if (drop_r) begin
        if (end_of_text) begin
          drop_nxt = 1'b0;
          pos_nxt = 2'd0;
          store_nxt = 18'd0;
          pad3_nxt = 1'b0;
          padded_nxt = 1'b0;
        end
      end else if (err != ERR_NONE) begin
        push = 1'b1;
        push_rec.group_bits = 24'd0;
        push_rec.byte_count = 2'd1;
        push_rec.err = err;
        if (end_of_text) begin
          pos_nxt = 2'd0;
          store_nxt = 18'd0;
          pad3_nxt = 1'b0;
          padded_nxt = 1'b0;
        end else begin
          drop_nxt = 1'b1;
        end
      end else if (pos_r != 2'd3) begin
        if (pos_r == 2'd2 && is_pad) begin
          pad3_nxt = 1'b1;
        end
        store_nxt = {store_r[11:0], val};
        pos_nxt = pos_r + 2'd1;
      end else begin
        push = 1'b1;
        if (pad3_r) begin
          push_rec.byte_count = 2'd1;
        end else if (is_pad) begin
          push_rec.byte_count = 2'd2;
        end
        pos_nxt = 2'd0;
        store_nxt = 18'd0;
        pad3_nxt = 1'b0;
        if (pad3_r || is_pad) begin
          padded_nxt = 1'b1;
        end
        if (end_of_text) begin
          padded_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 2'd0;
      store_r  <= 18'd0;
      pad3_r   <= 1'b0;
      padded_r <= 1'b0;
      drop_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      store_r  <= store_nxt;
      pad3_r   <= pad3_nxt;
      padded_r <= padded_nxt;
      drop_r   <= drop_nxt;
    end
  end

endmodule

// ===== rtl/core/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Short first-in first-out queue of group records between front and back.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64d_pkg::b64d_rec_t push_rec,
  input  logic                pop,
  output b64d_pkg::b64d_rec_t head_rec,
  output logic                empty,
  output logic                full
);
  import b64d_pkg::*;

  b64d_rec_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  always_comb begin
    empty      = (count_r == '0);
    full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
    head_rec   = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Splits each queued record into its result words, one per cycle unless out_tready
// holds the output back, through an output register.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b64d_pkg::b64d_rec_t head_rec,
  input  logic                empty,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic [0:0]          out_tuser,
  output logic                out_tlast
);
  import b64d_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  b64d_err_t  err_r, err_nxt;
  logic       run_last_r, run_last_nxt;
  logic       eom_r, eom_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic load;
  logic is_last;

  always_comb begin
    load    = !empty && (!valid_r || out_tready);
    is_last = (idx_r == head_rec.byte_count - 2'd1);
    pop     = load && is_last;

    valid_nxt    = valid_r;
    byte_nxt     = byte_r;
    err_nxt      = err_r;
    run_last_nxt = run_last_r;
    eom_nxt      = eom_r;
    idx_nxt      = idx_r;

    if (load) begin
      valid_nxt = 1'b1;
      case (idx_r)
        2'd0:    byte_nxt = head_rec.group_bits[23:16];
        2'd1:    byte_nxt = head_rec.group_bits[15:8];
        default: byte_nxt = head_rec.group_bits[7:0];
      endcase
      err_nxt      = head_rec.err;
      run_last_nxt = is_last;
      eom_nxt      = is_last && head_rec.eot;
      idx_nxt      = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    err_r      <= err_nxt;
    run_last_r <= run_last_nxt;
    eom_r      <= eom_nxt;
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = {5'd0, err_r, byte_r};
  assign out_tuser[0] = run_last_r;
  assign out_tlast    = eom_r;

endmodule

// ===== rtl/core/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: one character word in, decoded byte words out.
// ----------------------------------------------------------------------------
// The decoder takes one character every cycle as long as its four-entry group
// queue has room, and each fourth character of a group yields up to three
// byte words, which leave one per cycle from the output register while
// out_tready is high, so input stalls only when the output side holds back
// for long enough to fill the queue.
// An error yields a single word with a zero byte and a nonzero error code,
// after which characters are discarded until the end-of-text word.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data_byte[7:0], error_code[10:8], zeros
  output logic [0:0]  out_tuser,  // last_of_run
  output logic        out_tlast   // end_of_message
);
  import b64d_pkg::*;

  logic      accept;
  logic      push;
  logic      pop;
  logic      empty;
  logic      full;
  b64d_rec_t push_rec;
  b64d_rec_t head_rec;

  assign in_tready = !full;
  assign accept    = in_tvalid && !full;

  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_tdata),
    .end_of_text (in_tlast),
    .push        (push),
    .push_rec    (push_rec)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (empty),
    .full     (full)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (head_rec),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
